FILE: rtl/core/bsf_pkg.sv
// Package for the 3x3 box sum filter: field widths, defaults and shared types.
// No dependencies; every other file of the block refers to it by scoped name.
`default_nettype none

package bsf_pkg;

  localparam int PIX_PORT_BITS   = 8;
  localparam int SUM_BITS        = 12;
  localparam int IDX_BITS        = 10;
  localparam int SIDE_BITS       = 11;
  localparam int MAX_PIXEL_BITS  = 16;

  localparam int MAX_SIDE_DEFAULT   = 1024;
  localparam int PIXEL_BITS_DEFAULT = 8;
  localparam int MIN_SIDE           = 3;
  localparam int FIRST_EMIT_IDX     = 2;

  // control from the read stage to the window stage
  typedef struct packed {
    logic advance;
    logic emit;
  } win_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsf_if.sv
// Valid/ready channels of the box sum filter: pixel input and sum output.
// Depends on bsf_pkg for payload widths.
`default_nettype none

interface bsf_pix_if;
  logic                              valid;
  logic                              ready;
  logic [bsf_pkg::PIX_PORT_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bsf_sum_if;
  logic                         valid;
  logic                         ready;
  logic [bsf_pkg::SUM_BITS-1:0] box_sum;
  logic [bsf_pkg::IDX_BITS-1:0] centre_row;
  logic [bsf_pkg::IDX_BITS-1:0] centre_col;

  modport source (output valid, output box_sum, output centre_row, output centre_col,
                  input ready);
  modport sink (input valid, input box_sum, input centre_row, input centre_col,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/box_sum_3x3_filter_top.sv
// Top level of the 3x3 box sum filter: scan counters, side length register,
// read stage and assertions. Uses bsf_pkg, bsf_if, bsf_line_mem, bsf_window.
//
//   channel   dir  beat payload                       handshake
//   in_i      in   pixel[7:0]                         valid/ready
//   out_o     out  box_sum[11:0] centre_row/col[9:0]  valid/ready
//   cfg       in   cfg_wdata_i[10:0] side length      cfg_we_i, no stall
//
// One pixel per cycle unless out_o stalls; results leave from the window stage.
// The line memory is read at the pixel's column on acceptance and written back
// as the read stage advances, one read and one write port per cycle.
// Reset clears counters, side length (to MAX_SIDE) and column sums; line memory
// content is undefined until rows 0 and 1 of a frame have passed.
// A stalled output holds the read stage, which then drops in_i.ready.
`default_nettype none

module box_sum_3x3_filter_top #(
  parameter int MAX_SIDE   = bsf_pkg::MAX_SIDE_DEFAULT,
  parameter int PIXEL_BITS = bsf_pkg::PIXEL_BITS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bsf_pkg::SIDE_BITS-1:0] cfg_wdata_i,
  bsf_pix_if.sink                            in_i,
  bsf_sum_if.source                          out_o
);

  localparam int IdxW = $clog2(MAX_SIDE);

  logic [IdxW-1:0]       side_last_q, side_last_d;
  logic [IdxW-1:0]       row_q, col_q;
  logic                  in_fire;
  logic [bsf_pkg::MAX_PIXEL_BITS-1:0] pix_wide;
  logic [PIXEL_BITS-1:0] pix;
  logic [31:0]           side_req;

  logic                  s1_valid_q, s1_emit_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [IdxW-1:0]       s1_row_q, s1_col_q;
  logic                  s1_adv;
  logic                  win_free;
  logic [PIXEL_BITS-1:0] rd_top, rd_mid;
  bsf_pkg::win_ctrl_t    win_ctrl;

  assign pix_wide   = bsf_pkg::MAX_PIXEL_BITS'(in_i.pixel);
  assign pix        = pix_wide[PIXEL_BITS-1:0];
  assign s1_adv     = s1_valid_q && win_free;
  assign in_i.ready = !s1_valid_q || win_free;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    side_req = 32'(cfg_wdata_i);
    if (side_req < 32'(bsf_pkg::MIN_SIDE)) begin
      side_req = 32'(bsf_pkg::MIN_SIDE);
    end else if (side_req > 32'(MAX_SIDE)) begin
      side_req = 32'(MAX_SIDE);
    end
    side_last_d = IdxW'(side_req - 32'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_last_q <= IdxW'(MAX_SIDE - 1);
      row_q       <= '0;
      col_q       <= '0;
    end else if (cfg_we_i) begin
      side_last_q <= side_last_d;
      row_q       <= '0;
      col_q       <= '0;
    end else if (in_fire) begin
      if (col_q == side_last_q) begin
        col_q <= '0;
        row_q <= (row_q == side_last_q) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pix;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_emit_q <= (row_q >= IdxW'(bsf_pkg::FIRST_EMIT_IDX))
                && (col_q >= IdxW'(bsf_pkg::FIRST_EMIT_IDX));
    end
  end

  bsf_line_mem #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_top_o  (rd_top),
    .rd_mid_o  (rd_mid),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_mid_i  (rd_mid),
    .wr_pix_i  (s1_pix_q)
  );

  assign win_ctrl.advance = s1_adv;
  assign win_ctrl.emit    = s1_emit_q;

  bsf_window #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .top_i  (rd_top),
    .mid_i  (rd_mid),
    .pix_i  (s1_pix_q),
    .row_i  (s1_row_q),
    .col_i  (s1_col_q),
    .free_o (win_free),
    .sum_o  (out_o)
  );

`ifndef SYNTHESIS
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= side_last_q)
    else $error("column counter beyond side length");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= side_last_q)
    else $error("row counter beyond side length");

  a_accept_loads_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted beat lost before read stage");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !win_free |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_pix_q))
    else $error("read stage changed while stalled");

  a_emit_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_emit_q |=> out_o.valid)
    else $error("result beat missing after window advance");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/bsf_line_mem.sv
// Line buffer memory: one entry per column holds the rows two above and one above.
// Synchronous read into a register, with write-to-read forwarding. Uses bsf_pkg.
`default_nettype none

module bsf_line_mem #(
  parameter int MAX_SIDE   = bsf_pkg::MAX_SIDE_DEFAULT,
  parameter int PIXEL_BITS = bsf_pkg::PIXEL_BITS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0]   rd_addr_i,
  output      logic [PIXEL_BITS-1:0]         rd_top_o,
  output      logic [PIXEL_BITS-1:0]         rd_mid_o,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0]   wr_addr_i,
  input  wire logic [PIXEL_BITS-1:0]         wr_mid_i,
  input  wire logic [PIXEL_BITS-1:0]         wr_pix_i
);

  localparam int EntryBits = 2 * PIXEL_BITS;

  logic [EntryBits-1:0] mem [MAX_SIDE];
  logic [EntryBits-1:0] rd_q;
  logic [EntryBits-1:0] wr_data;

  assign wr_data = {wr_mid_i, wr_pix_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_top_o = rd_q[EntryBits-1:PIXEL_BITS];
  assign rd_mid_o = rd_q[PIXEL_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/bsf_window.sv
// Window stage: keeps the two older column sums, adds the new column and
// registers the result beat. Uses bsf_pkg and the bsf_sum_if channel.
`default_nettype none

module bsf_window #(
  parameter int MAX_SIDE   = bsf_pkg::MAX_SIDE_DEFAULT,
  parameter int PIXEL_BITS = bsf_pkg::PIXEL_BITS_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bsf_pkg::win_ctrl_t          ctrl_i,
  input  wire logic [PIXEL_BITS-1:0]       top_i,
  input  wire logic [PIXEL_BITS-1:0]       mid_i,
  input  wire logic [PIXEL_BITS-1:0]       pix_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0] row_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0] col_i,
  output      logic                        free_o,
  bsf_sum_if.source                        sum_o
);

  localparam int ColBits = PIXEL_BITS + 2;
  localparam int BoxBits = PIXEL_BITS + 4;

  logic [ColBits-1:0]           cs0_q, cs1_q;
  logic [ColBits-1:0]           cs_new;
  logic [BoxBits-1:0]           box;
  logic                         valid_q;
  logic [bsf_pkg::SUM_BITS-1:0] sum_q;
  logic [bsf_pkg::IDX_BITS-1:0] row_q, col_q;

  assign cs_new = ColBits'(top_i) + ColBits'(mid_i) + ColBits'(pix_i);
  assign box    = BoxBits'(cs0_q) + BoxBits'(cs1_q) + BoxBits'(cs_new);
  assign free_o = !valid_q || sum_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs0_q   <= '0;
      cs1_q   <= '0;
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      cs0_q   <= cs1_q;
      cs1_q   <= cs_new;
      valid_q <= ctrl_i.emit;
    end else if (sum_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance && ctrl_i.emit) begin
      sum_q <= bsf_pkg::SUM_BITS'(box);
      row_q <= bsf_pkg::IDX_BITS'(row_i - 1'b1);
      col_q <= bsf_pkg::IDX_BITS'(col_i - 1'b1);
    end
  end

  assign sum_o.valid      = valid_q;
  assign sum_o.box_sum    = sum_q;
  assign sum_o.centre_row = row_q;
  assign sum_o.centre_col = col_q;

endmodule

`default_nettype wire
